// ----- rtl/dsfp_pkg.sv -----
// Shared constants and types for the dust sensor frame parser.
// Standalone package; used by dust_sensor_frame_parser.
`default_nettype none

package dsfp_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned WORD_W = 16;
   localparam int unsigned SCALED_W = 13;

   // Frame start marker
   localparam logic [BYTE_W-1:0] HEAD_FIRST = 8'h42;
   localparam logic [BYTE_W-1:0] HEAD_SECOND = 8'h4D;

   // Byte offsets of the big-endian data words kept from a frame
   localparam int unsigned OFS_PM_FIRST = 6;
   localparam int unsigned OFS_PM_SECOND = 8;
   localparam int unsigned OFS_PM_THIRD = 12;
   localparam int unsigned OFS_PM_FOURTH = 14;
   localparam int unsigned OFS_TEMP = 24;
   localparam int unsigned OFS_HUMID = 26;

   // x / 10 == (x * 52429) >> 19 for every 16-bit x
   localparam int unsigned PROD_W = 32;
   localparam logic [WORD_W-1:0] DIV10_RECIP = 16'd52429;
   localparam int unsigned DIV10_SHIFT = 19;

   // Raw words of a matched frame, held between the window check and the output
   typedef struct packed {
      logic [WORD_W-1:0] pm_first;
      logic [WORD_W-1:0] pm_second;
      logic [WORD_W-1:0] pm_third;
      logic [WORD_W-1:0] pm_fourth;
      logic [WORD_W-1:0] temp_raw;
      logic [WORD_W-1:0] humid_raw;
   } frame_words_type;

endpackage

`default_nettype wire

// ----- rtl/dust_sensor_frame_parser.sv -----
// Dust sensor frame parser: byte window, header match and result output.
// Depends on dsfp_pkg for constants and the frame word struct.
//
// Usage: one received serial byte enters per req_ item (req_valid/req_ready).
// The last FRAME_BYTES-1 bytes are kept in a shift line with a fill count.
// When a byte completes a full window that starts with 0x42 0x4D, one rsp_
// item carries data words 2, 3, 5, 6 and words 11, 12 divided by ten; the
// window then empties. A full window without the marker drops its oldest byte.
// Throughput: one byte per cycle while the output drains. The window check
// sits between the shift line and a word register; the divide by ten
// (reciprocal multiply) sits between that register and the output register.
// A frame's result passes through the word register and then the output
// register before it is valid on rsp_.
// Reset clears the fill count and both valid flags; the window contents are
// left as they are. When rsp_ready stays low, the result holds and the word
// register fills; req_ready then drops until the output drains, and no byte
// is lost.
`default_nettype none

module dust_sensor_frame_parser #(
   parameter int unsigned FRAME_BYTES = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_pm_first,
   output logic [15:0]      rsp_pm_second,
   output logic [15:0]      rsp_pm_third,
   output logic [15:0]      rsp_pm_fourth,
   output logic [12:0]      rsp_temperature_scaled,
   output logic [12:0]      rsp_humidity_scaled
);

   localparam int unsigned HOLD_DEPTH = FRAME_BYTES - 1;
   localparam int unsigned CNT_W = $clog2(FRAME_BYTES);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(HOLD_DEPTH);

   logic [dsfp_pkg::BYTE_W-1:0] win_ff [HOLD_DEPTH];
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [dsfp_pkg::BYTE_W-1:0] frame_bytes [FRAME_BYTES];

   logic                        accept;
   logic                        full;
   logic                        hit;

   dsfp_pkg::frame_words_type   words_ff, words_in;
   logic                        words_valid_ff, words_valid_in;
   logic                        out_free;
   logic                        words_free;

   logic [dsfp_pkg::PROD_W-1:0] temp_prod;
   logic [dsfp_pkg::PROD_W-1:0] humid_prod;

   logic                        rsp_valid_ff;
   logic [15:0]                 pm_first_ff, pm_second_ff, pm_third_ff, pm_fourth_ff;
   logic [12:0]                 temp_ff, humid_ff;

   // Handshake: the output register frees the word register, which frees input
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign words_free = !words_valid_ff || out_free;
   assign req_ready = words_free;
   assign accept = req_valid && req_ready;

   // Window as seen with the incoming byte appended at the end
   always_comb begin
      for (int k = 0; k < HOLD_DEPTH; k++) begin
         frame_bytes[k] = win_ff[k];
      end
      frame_bytes[FRAME_BYTES-1] = req_rx_byte;
   end

   assign full = (cnt_ff == CNT_FULL);
   assign hit = full && (frame_bytes[0] == dsfp_pkg::HEAD_FIRST)
                     && (frame_bytes[1] == dsfp_pkg::HEAD_SECOND);

   always_comb begin
      words_in.pm_first = {frame_bytes[dsfp_pkg::OFS_PM_FIRST],
                           frame_bytes[dsfp_pkg::OFS_PM_FIRST+1]};
      words_in.pm_second = {frame_bytes[dsfp_pkg::OFS_PM_SECOND],
                            frame_bytes[dsfp_pkg::OFS_PM_SECOND+1]};
      words_in.pm_third = {frame_bytes[dsfp_pkg::OFS_PM_THIRD],
                           frame_bytes[dsfp_pkg::OFS_PM_THIRD+1]};
      words_in.pm_fourth = {frame_bytes[dsfp_pkg::OFS_PM_FOURTH],
                            frame_bytes[dsfp_pkg::OFS_PM_FOURTH+1]};
      words_in.temp_raw = {frame_bytes[dsfp_pkg::OFS_TEMP],
                           frame_bytes[dsfp_pkg::OFS_TEMP+1]};
      words_in.humid_raw = {frame_bytes[dsfp_pkg::OFS_HUMID],
                            frame_bytes[dsfp_pkg::OFS_HUMID+1]};
   end

   // Empty on a frame, hold at full otherwise once full
   always_comb begin
      cnt_in = cnt_ff;
      if (accept) begin
         if (hit) begin
            cnt_in = '0;
         end else if (!full) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      words_valid_in = words_valid_ff;
      if (words_free) begin
         words_valid_in = accept && hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         words_valid_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         words_valid_ff <= words_valid_in;
      end
   end

   // Advance the shift line on every accepted byte; only the newest cnt_ff are live
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int k = 0; k < HOLD_DEPTH - 1; k++) begin
            win_ff[k] <= win_ff[k+1];
         end
         win_ff[HOLD_DEPTH-1] <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (words_free && accept && hit) begin
         words_ff <= words_in;
      end
   end

   // Divide by ten through the reciprocal
   assign temp_prod = {16'b0, words_ff.temp_raw} * {16'b0, dsfp_pkg::DIV10_RECIP};
   assign humid_prod = {16'b0, words_ff.humid_raw} * {16'b0, dsfp_pkg::DIV10_RECIP};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= words_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && words_valid_ff) begin
         pm_first_ff <= words_ff.pm_first;
         pm_second_ff <= words_ff.pm_second;
         pm_third_ff <= words_ff.pm_third;
         pm_fourth_ff <= words_ff.pm_fourth;
         temp_ff <= temp_prod[dsfp_pkg::DIV10_SHIFT +: dsfp_pkg::SCALED_W];
         humid_ff <= humid_prod[dsfp_pkg::DIV10_SHIFT +: dsfp_pkg::SCALED_W];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pm_first = pm_first_ff;
   assign rsp_pm_second = pm_second_ff;
   assign rsp_pm_third = pm_third_ff;
   assign rsp_pm_fourth = pm_fourth_ff;
   assign rsp_temperature_scaled = temp_ff;
   assign rsp_humidity_scaled = humid_ff;

endmodule

`default_nettype wire
